// ===== rtl/core/run_length_sequence_store_macros.svh =====
// Assertion macros shared by the run-length sequence store RTL.
// Depends on nothing; the including module must have i_clk and i_rst_n.
// The checks are compiled out when ASSERT_OFF is defined.
`ifndef RUN_LENGTH_SEQUENCE_STORE_MACROS_SVH
`define RUN_LENGTH_SEQUENCE_STORE_MACROS_SVH

`ifndef ASSERT_OFF
// The property must hold at every clock edge outside reset.
`define RLSS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// The expression must never be true outside reset.
`define RLSS_NEVER(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) else $error(msg);
`else
`define RLSS_ASSERT(label, prop, msg)
`define RLSS_NEVER(label, expr, msg)
`endif

`endif

// ===== rtl/core/rlss_pkg.sv =====
// Package for the run-length sequence store: sizes, codes, item types and
// the command and status groups between controller and datapath.
// Depends on nothing.
`default_nettype none

package rlss_pkg;

    localparam int MAX_RUNS = 256;
    localparam int LEN_W    = 16;
    localparam int VAL_W    = 32;
    localparam int FIELD_W  = 32;
    localparam int QTY_W    = 16;
    localparam int POS_W    = 16;
    localparam int IDX_W    = $clog2(MAX_RUNS);
    localparam int CNT_W    = $clog2(MAX_RUNS + 1);
    localparam int SUM_W    = ((LEN_W > QTY_W) ? LEN_W : QTY_W) + 1;

    localparam logic [SUM_W-1:0] LEN_LIMIT = SUM_W'((64'd1 << LEN_W) - 64'd1);

    typedef enum logic [1:0] {
        REQ_APPEND = 2'd0,
        REQ_READ   = 2'd1,
        REQ_FIND   = 2'd2,
        REQ_NONE   = 2'd3
    } t_req_code;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_TABLE_FULL = 2'd1,
        ST_LEN_LIMIT  = 2'd2,
        ST_UNUSED     = 2'd3
    } t_status_code;

    typedef struct packed {
        logic [1:0]                req_type;
        logic signed [FIELD_W-1:0] item_value;
        logic [QTY_W-1:0]          repeat_qty;
        logic [POS_W-1:0]          position_in;
    } t_request;

    typedef struct packed {
        logic signed [FIELD_W-1:0] value_out;
        logic [POS_W-1:0]          position_out;
        logic                      hit;
        logic [1:0]                status;
    } t_result;

    typedef struct packed {
        logic load;
        logic append;
        logic emit_miss;
        logic scan_start;
        logic scan_step;
        logic scan_emit;
    } t_cmd;

    typedef struct packed {
        t_req_code req_code;
        logic      quick_miss;
        logic      scan_done;
    } t_dp_status;

    // Input value as held in the table: sign-extended, then cut to VAL_W bits.
    function automatic logic [VAL_W-1:0] to_stored(logic signed [FIELD_W-1:0] v);
        logic signed [63:0] w;
        w = 64'(v);
        return w[VAL_W-1:0];
    endfunction

    // Stored value back to the result field, sign-extended from VAL_W bits.
    function automatic logic signed [FIELD_W-1:0] to_field(logic [VAL_W-1:0] v);
        logic signed [63:0] w;
        w = 64'(signed'(v));
        return w[FIELD_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rlss_controller.sv =====
// Sequencing state machine of the run-length sequence store.
// Depends on rlss_pkg; drives the datapath only through t_cmd.
`default_nettype none

module rlss_controller (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  rlss_pkg::t_dp_status i_status,
    output rlss_pkg::t_cmd     o_cmd,
    output logic               o_busy
);
    import rlss_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE     = 3'b001,
        S_DISPATCH = 3'b010,
        S_SCAN     = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;
    t_cmd   cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    cmd.load = 1'b1;
                    n_state  = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_state = S_IDLE;
                unique case (i_status.req_code) inside
                    REQ_APPEND: begin
                        cmd.append = 1'b1;
                    end
                    REQ_READ, REQ_FIND: begin
                        if (i_status.quick_miss) begin
                            cmd.emit_miss = 1'b1;
                        end else begin
                            cmd.scan_start = 1'b1;
                            n_state        = S_SCAN;
                        end
                    end
                    default: begin
                        cmd.emit_miss = 1'b1;
                    end
                endcase
            end
            S_SCAN: begin
                // The walk stops on the run that decides the result, so the
                // scan pointers keep pointing at that run afterwards.
                if (i_status.scan_done) begin
                    cmd.scan_emit = 1'b1;
                    n_state       = S_IDLE;
                end else begin
                    cmd.scan_step = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd  = cmd;
    assign o_busy = (r_state != S_IDLE);

endmodule

`default_nettype wire

// ===== rtl/core/rlss_datapath.sv =====
// Datapath of the run-length sequence store: run table memories, length
// bookkeeping, the run scan and the result register.
// Depends on rlss_pkg and run_length_sequence_store_macros.svh.
`default_nettype none
`include "run_length_sequence_store_macros.svh"

module rlss_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rlss_pkg::t_request   i_request,
    input  rlss_pkg::t_cmd       i_cmd,
    output rlss_pkg::t_dp_status o_status,
    output logic                 o_valid,
    output rlss_pkg::t_result    o_result
);
    import rlss_pkg::*;

    // Run table; entries at or above r_runs_used are never examined.
    logic [VAL_W-1:0] mem_value [MAX_RUNS];
    logic [LEN_W-1:0] mem_count [MAX_RUNS];

    t_request         r_req;
    logic [CNT_W-1:0] r_runs_used;
    logic [LEN_W-1:0] r_total;
    logic [VAL_W-1:0] r_last_value;
    logic [LEN_W-1:0] r_last_count;

    logic [IDX_W-1:0] r_rd_idx;
    logic [IDX_W-1:0] r_chk_idx;
    logic [VAL_W-1:0] r_q_value;
    logic [LEN_W-1:0] r_q_count;
    logic             r_q_vld;
    logic [LEN_W-1:0] r_acc;

    logic             r_valid;
    logic             n_valid;
    t_result          r_result;
    t_result          n_result;

    logic [VAL_W-1:0] req_val;
    logic [SUM_W-1:0] sum;
    logic             extend;
    logic             table_full;
    t_status_code     append_status;
    logic             append_en;
    logic [IDX_W-1:0] wr_idx;
    logic [LEN_W-1:0] new_count;
    logic [SUM_W-1:0] acc_end;
    logic             read_hit;
    logic             find_hit;
    logic             scan_hit;
    logic             scan_last;
    logic             is_read;
    logic             is_find;

    assign req_val    = to_stored(r_req.item_value);
    assign is_read    = (r_req.req_type == REQ_READ);
    assign is_find    = (r_req.req_type == REQ_FIND);

    // Append: the last run is shadowed in registers so no memory read is needed.
    assign sum        = SUM_W'(r_total) + SUM_W'(r_req.repeat_qty);
    assign extend     = (r_runs_used != '0) && (r_last_value == req_val);
    assign table_full = (r_runs_used == CNT_W'(MAX_RUNS));

    always_comb begin
        if (r_req.repeat_qty == '0) begin
            append_status = ST_OK;
        end else if (sum > LEN_LIMIT) begin
            append_status = ST_LEN_LIMIT;
        end else if (!extend && table_full) begin
            append_status = ST_TABLE_FULL;
        end else begin
            append_status = ST_OK;
        end
    end

    assign append_en = i_cmd.append && (r_req.repeat_qty != '0) && (append_status == ST_OK);
    assign wr_idx    = extend ? IDX_W'(r_runs_used - CNT_W'(1)) : IDX_W'(r_runs_used);
    assign new_count = extend ? (r_last_count + LEN_W'(r_req.repeat_qty))
                              : LEN_W'(r_req.repeat_qty);

    // Scan: one run checked per cycle against registered memory data.
    assign acc_end   = SUM_W'(r_acc) + SUM_W'(r_q_count);
    assign read_hit  = SUM_W'(r_req.position_in) < acc_end;
    assign find_hit  = (r_q_value == req_val);
    assign scan_hit  = is_read ? read_hit : find_hit;
    assign scan_last = (CNT_W'(r_chk_idx) == (r_runs_used - CNT_W'(1)));

    assign o_status.req_code   = t_req_code'(r_req.req_type);
    assign o_status.quick_miss = (is_read && (SUM_W'(r_req.position_in) >= SUM_W'(r_total)))
                               || (is_find && (r_runs_used == '0));
    assign o_status.scan_done  = r_q_vld && (scan_hit || scan_last);

    always_comb begin
        n_valid  = 1'b0;
        n_result = '0;
        if (i_cmd.append) begin
            n_valid         = 1'b1;
            n_result.status = append_status;
        end else if (i_cmd.emit_miss) begin
            n_valid = 1'b1;
        end else if (i_cmd.scan_emit) begin
            n_valid      = 1'b1;
            n_result.hit = scan_hit;
            if (scan_hit && is_read) begin
                n_result.value_out = to_field(r_q_value);
            end
            if (scan_hit && is_find) begin
                n_result.position_out = POS_W'(r_acc);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (append_en) begin
            mem_value[wr_idx] <= req_val;
            mem_count[wr_idx] <= new_count;
        end
        r_q_value <= mem_value[r_rd_idx];
        r_q_count <= mem_count[r_rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_request;
        end
        if (append_en) begin
            r_last_value <= req_val;
            r_last_count <= new_count;
        end
        if (i_cmd.scan_start) begin
            r_rd_idx <= '0;
            r_acc    <= '0;
        end else if (i_cmd.scan_step) begin
            r_rd_idx  <= r_rd_idx + IDX_W'(1);
            r_chk_idx <= r_rd_idx;
            if (r_q_vld) begin
                r_acc <= r_acc + r_q_count;
            end
        end
        r_result <= n_result;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_runs_used <= '0;
            r_total     <= '0;
            r_q_vld     <= 1'b0;
            r_valid     <= 1'b0;
        end else begin
            if (append_en) begin
                r_total <= LEN_W'(sum);
                if (!extend) begin
                    r_runs_used <= r_runs_used + CNT_W'(1);
                end
            end
            if (i_cmd.scan_start) begin
                r_q_vld <= 1'b0;
            end else if (i_cmd.scan_step) begin
                r_q_vld <= 1'b1;
            end
            r_valid <= n_valid;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

    `RLSS_NEVER(a_runs_bound, r_runs_used > CNT_W'(MAX_RUNS), "run count beyond table size")
    `RLSS_ASSERT(a_chk_in_table, r_q_vld |-> (CNT_W'(r_chk_idx) < r_runs_used),
                 "scan examined a run outside the table")
    `RLSS_ASSERT(a_single_strobe, r_valid |=> !r_valid, "result strobe held for two cycles")
    `RLSS_ASSERT(a_reject_holds, (i_cmd.append && (append_status != ST_OK))
                 |=> ($stable(r_runs_used) && $stable(r_total)),
                 "rejected append changed the table")

endmodule

`default_nettype wire

// ===== rtl/core/run_length_sequence_store.sv =====
// Top level of the run-length sequence store.
// Depends on rlss_pkg, rlss_controller and rlss_datapath.
//
// The block keeps a sequence as a table of runs (value and repeat count)
// together with the total expanded length. A request item is accepted at a
// rising edge where start is high and busy is low. The request may append a
// value with a quantity, read the element at an expanded index, or find the
// expanded index of the first occurrence of a value.
// Every accepted item gives exactly one result item, shown on o_result for
// a single cycle while o_valid is high. The receiver cannot hold results
// off, so nothing here waits on it.
// An append, an unused request code, or a read or find that misses without
// looking at the table keeps busy high only through the dispatch state, and the
// result is shown in the first cycle with busy low. A read or find walks the
// run table through a registered memory read: the dispatch state, a first
// read, then one run per cycle; the walk ends at the first matching run and
// the result is shown in the first cycle with busy low. The next item may be
// started in the cycle in which busy falls.
// Reset empties the table by clearing the run and length counters; the run
// memories themselves are not cleared, as only runs below the run count are
// ever examined.
`default_nettype none

module run_length_sequence_store (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  rlss_pkg::t_request i_request,
    output logic               busy,
    output logic               o_valid,
    output rlss_pkg::t_result  o_result
);
    import rlss_pkg::*;

    t_cmd       cmd;
    t_dp_status dp_status;

    // The controller sequences each request; all storage sits in the datapath.
    rlss_controller u_controller (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (dp_status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    // The request is registered on acceptance, so i_request need only be
    // stable at the accepting edge.
    rlss_datapath u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_request (i_request),
        .i_cmd     (cmd),
        .o_status  (dp_status),
        .o_valid   (o_valid),
        .o_result  (o_result)
    );

endmodule

`default_nettype wire
